// ===== design/cla_pkg.sv =====
//------------------------------------------------------------------------------
// cla_pkg
// Shared types and constants of the argument splitter.
//------------------------------------------------------------------------------
`default_nettype none

package cla_pkg;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // results one input word can cause
  localparam int unsigned NRES  = 3;
  localparam int unsigned CNT_W = $clog2(NRES + 1);

  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_DOUBLE = 2'd1,
    Q_SINGLE = 2'd2
  } quote_t;

  typedef struct packed {
    logic   held;
    quote_t quote;
    logic   arg;
  } state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       kind;
    logic       last;
  } res_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

endpackage

`default_nettype wire

// ===== design/cla_in_if.sv =====
//------------------------------------------------------------------------------
// cla_in_if
// Input channel: one command byte per word.
//------------------------------------------------------------------------------
`default_nettype none

interface cla_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

`default_nettype wire

// ===== design/cla_out_if.sv =====
//------------------------------------------------------------------------------
// cla_out_if
// Result channel: one argument byte or end marker per word.
//------------------------------------------------------------------------------
`default_nettype none

interface cla_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_kind;
  logic       out_last;

  modport source (output valid, output out_byte, output out_kind, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input out_kind, input out_last,
                  output ready);
endinterface

`default_nettype wire

// ===== design/cla_step.sv =====
//------------------------------------------------------------------------------
// cla_step
// Tokenizer state and the per-byte result list for the current input word.
//------------------------------------------------------------------------------
`default_nettype none

module cla_step
  import cla_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic              split_only,
  input  wire logic [7:0]        in_byte,
  input  wire logic              is_last,
  output res_t [NRES-1:0]        res,
  output logic [CNT_W-1:0]       res_cnt
);

  state_t           st_r;
  state_t           st_nxt;
  res_t [NRES-1:0]  res_v;
  logic [CNT_W-1:0] n_v;
  logic             esc;
  logic [7:0]       qc;

  always_comb begin
    st_nxt      = st_r;
    st_nxt.held = 1'b0;
    n_v         = '0;
    res_v       = '0;
    esc         = st_r.held && ((in_byte == CH_BSLASH) || (in_byte == CH_DQUOTE));
    qc          = (st_r.quote == Q_DOUBLE) ? CH_DQUOTE : CH_SQUOTE;

    // held backslash
    if (st_r.held && (!esc || split_only)) begin
      st_nxt.arg = 1'b1;
      res_v[n_v] = '{data: CH_BSLASH, kind: KIND_BYTE, last: 1'b0};
      n_v        = n_v + 1'b1;
    end

    if (esc) begin
      if (st_nxt.arg || !is_ws(in_byte)) begin
        st_nxt.arg = 1'b1;
        res_v[n_v] = '{data: in_byte, kind: KIND_BYTE, last: 1'b0};
        n_v        = n_v + 1'b1;
      end
    end else if ((st_r.quote == Q_NONE) &&
                 ((in_byte == CH_DQUOTE) || (in_byte == CH_SQUOTE))) begin
      st_nxt.quote = (in_byte == CH_DQUOTE) ? Q_DOUBLE : Q_SINGLE;
      if (split_only) begin
        st_nxt.arg = 1'b1;
        res_v[n_v] = '{data: in_byte, kind: KIND_BYTE, last: 1'b0};
        n_v        = n_v + 1'b1;
      end
    end else if ((st_r.quote != Q_NONE) && (in_byte == qc)) begin
      st_nxt.quote = Q_NONE;
      if (split_only) begin
        st_nxt.arg = 1'b1;
        res_v[n_v] = '{data: in_byte, kind: KIND_BYTE, last: 1'b0};
        n_v        = n_v + 1'b1;
      end
    end else if ((in_byte == CH_BSLASH) && !is_last) begin
      st_nxt.held = 1'b1;
    end else if ((st_r.quote == Q_NONE) && is_ws(in_byte)) begin
      if (st_nxt.arg) begin
        res_v[n_v] = '{data: 8'd0, kind: KIND_END, last: 1'b0};
        n_v        = n_v + 1'b1;
      end
      st_nxt.arg = 1'b0;
    end else if (st_nxt.arg || !is_ws(in_byte)) begin
      st_nxt.arg = 1'b1;
      res_v[n_v] = '{data: in_byte, kind: KIND_BYTE, last: 1'b0};
      n_v        = n_v + 1'b1;
    end

    // end of string
    if (is_last) begin
      if (st_nxt.arg) begin
        res_v[n_v] = '{data: 8'd0, kind: KIND_END, last: 1'b0};
        n_v        = n_v + 1'b1;
      end
      st_nxt.arg   = 1'b0;
      st_nxt.quote = Q_NONE;
      st_nxt.held  = 1'b0;
    end

    if (n_v != '0) begin
      res_v[n_v - 1'b1].last = 1'b1;
    end
  end

  assign res     = res_v;
  assign res_cnt = n_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{held: 1'b0, quote: Q_NONE, arg: 1'b0};
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/command_line_argument_splitter.sv =====
//------------------------------------------------------------------------------
// command_line_argument_splitter
// Streaming shell-style splitter: command bytes in, argument bytes and end
// markers out, through a small result buffer.
//------------------------------------------------------------------------------
// latency: first result of a word is valid the cycle after the word is taken
// throughput: one input word per cycle while each word gives at most one result and the output is ready
// a word that gives k results (k up to 3) holds off input until its last result is being taken
// reset: clears tokenizer state and split_only, and empties the result buffer
//------------------------------------------------------------------------------
`default_nettype none

module command_line_argument_splitter
  import cla_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata,
  cla_in_if.sink     in_ch,
  cla_out_if.source  out_ch
);

  logic             split_only_r;
  res_t [NRES-1:0]  res_r;
  res_t [NRES-1:0]  res_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  res_t [NRES-1:0]  step_res;
  logic [CNT_W-1:0] step_cnt;
  logic             accept;
  logic             pop;

  assign out_ch.valid    = (cnt_r != '0);
  assign pop             = out_ch.valid && out_ch.ready;
  assign in_ch.ready     = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_ch.ready);
  assign accept          = in_ch.valid && in_ch.ready;

  assign out_ch.out_byte = res_r[0].data;
  assign out_ch.out_kind = res_r[0].kind;
  assign out_ch.out_last = res_r[0].last;

  cla_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .split_only (split_only_r),
    .in_byte    (in_ch.in_byte),
    .is_last    (in_ch.is_last),
    .res        (step_res),
    .res_cnt    (step_cnt)
  );

  always_comb begin
    res_nxt = res_r;
    cnt_nxt = cnt_r;
    if (pop) begin
      for (int i = 0; i < NRES - 1; i++) begin
        res_nxt[i] = res_r[i + 1];
      end
      cnt_nxt = cnt_r - 1'b1;
    end
    if (accept) begin
      res_nxt = step_res;
      cnt_nxt = step_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      split_only_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_we) begin
        split_only_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // head word of a single-entry buffer closes its input's results
  a_last_single : assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CNT_W'(1)) |-> res_r[0].last)
    else $error("last flag missing on final buffered word");

  // more words pending from the same input means the head is not last
  a_not_last_multi : assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r > CNT_W'(1)) |-> !res_r[0].last)
    else $error("last flag set before final buffered word");

  // end markers carry a zero byte
  a_end_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (res_r[0].kind == KIND_END)) |-> (res_r[0].data == 8'd0))
    else $error("end marker with nonzero byte");

  // buffer never overflows its depth
  a_cnt_range : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (cnt_r <= CNT_W'(NRES)))
    else $error("result buffer count out of range");

endmodule

`default_nettype wire

// ===== dv/command_line_argument_splitter_test.sv =====
//------------------------------------------------------------------------------
// command_line_argument_splitter_test
// Self-checking bench for the argument splitter. Command strings go in one byte
// per word under random bursts and gaps. Each result word is checked against an
// in-bench tokenizer model, with the result side stalling on patterns of its
// own. Directed strings cover quoting and escapes, then random strings run under
// both split_only settings.
//------------------------------------------------------------------------------
`default_nettype none

module command_line_argument_splitter_test;
  import cla_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 10;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  cla_in_if  in_ch();
  cla_out_if out_ch();

  command_line_argument_splitter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // tokenizer model state
  logic       keep_marks;
  logic       esc_pending;
  logic [7:0] esc_byte;
  quote_t     quote_open;
  logic       arg_open;

  res_t step_words[$];
  res_t due_words[$];

  int   mismatches;
  int   cycles;
  bit   in_up;
  int   burst_left;
  int   ready_mode;
  int   mode_left;
  int   mode_tick;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic blank(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  task automatic put_word(input logic [7:0] b, input logic kind);
    res_t r;
    r.data = (kind == KIND_END) ? 8'h00 : b;
    r.kind = kind;
    r.last = 1'b0;
    step_words.push_back(r);
  endtask

  task automatic put_arg_byte(input logic [7:0] c);
    if (!arg_open && blank(c)) return;
    arg_open = 1'b1;
    put_word(c, KIND_BYTE);
  endtask

  task automatic take_plain(input logic [7:0] c, input logic last);
    logic [7:0] qc;
    logic       inq;
    qc  = (quote_open == Q_DOUBLE) ? CH_DQUOTE :
          (quote_open == Q_SINGLE) ? CH_SQUOTE : 8'h00;
    inq = (quote_open != Q_NONE);
    if (!inq && (c == CH_DQUOTE || c == CH_SQUOTE)) begin
      quote_open = (c == CH_DQUOTE) ? Q_DOUBLE : Q_SINGLE;
      if (keep_marks) put_arg_byte(c);
    end else if (inq && c == qc) begin
      quote_open = Q_NONE;
      if (keep_marks) put_arg_byte(c);
    end else if (c == CH_BSLASH && !last) begin
      esc_pending = 1'b1;
      esc_byte    = c;
    end else if (!inq && blank(c)) begin
      if (arg_open) put_word(8'h00, KIND_END);
      arg_open = 1'b0;
    end else begin
      put_arg_byte(c);
    end
  endtask

  task automatic tokenize_byte(input logic [7:0] b, input logic last);
    logic [7:0] h;
    res_t       r;
    step_words.delete();
    if (esc_pending) begin
      h           = esc_byte;
      esc_pending = 1'b0;
      esc_byte    = 8'h00;
      if (b == CH_BSLASH || b == CH_DQUOTE) begin
        if (keep_marks) put_arg_byte(h);
        put_arg_byte(b);
      end else begin
        put_arg_byte(h);
        take_plain(b, last);
      end
    end else begin
      take_plain(b, last);
    end
    if (last) begin
      if (arg_open) put_word(8'h00, KIND_END);
      arg_open    = 1'b0;
      quote_open  = Q_NONE;
      esc_pending = 1'b0;
      esc_byte    = 8'h00;
    end
    if (step_words.size() > 0) begin
      r      = step_words[step_words.size() - 1];
      r.last = 1'b1;
      step_words[step_words.size() - 1] = r;
    end
    foreach (step_words[i]) due_words.push_back(step_words[i]);
  endtask

  task automatic report_mismatch(input string what, input res_t exp_w, input res_t got_w);
    mismatches++;
    if (mismatches <= 10)
      $display("%0s: expected byte %02h kind %0b last %0b, got byte %02h kind %0b last %0b",
               what, exp_w.data, exp_w.kind, exp_w.last, got_w.data, got_w.kind, got_w.last);
  endtask

  always @(posedge clk) begin
    res_t got_w;
    res_t exp_w;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got_w.data = out_ch.out_byte;
      got_w.kind = out_ch.out_kind;
      got_w.last = out_ch.out_last;
      if (due_words.size() == 0) begin
        exp_w = '0;
        report_mismatch("unexpected word", exp_w, got_w);
      end else begin
        exp_w = due_words.pop_front();
        if (got_w.data !== exp_w.data || got_w.kind !== exp_w.kind ||
            got_w.last !== exp_w.last)
          report_mismatch("word mismatch", exp_w, got_w);
      end
    end
  end

  // result side stall patterns
  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(16, 80);
      mode_tick  = 0;
    end
    mode_left--;
    mode_tick++;
    case (ready_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= ((mode_tick % 5) < 2);
      default: out_ch.ready <= ((mode_tick % 16) >= 12);
    endcase
  end

  task automatic hold_input();
    if (in_up) begin
      in_ch.valid <= 1'b0;
      in_up = 1'b0;
    end
  endtask

  task automatic send_word(input logic [7:0] b, input logic last);
    int gap;
    in_ch.valid   <= 1'b1;
    in_up = 1'b1;
    in_ch.in_byte <= b;
    in_ch.is_last <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tokenize_byte(b, last);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        hold_input();
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], i == s.len() - 1);
  endtask

  task automatic wait_drained();
    hold_input();
    while (due_words.size() != 0) @(negedge clk);
  endtask

  task automatic set_split_only(input logic v);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    keep_marks = v;
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    case ($urandom_range(0, 9))
      0, 1: begin
        r = $urandom_range(0, 5);
        return (r == 5) ? 8'd32 : 8'(9 + r);
      end
      2: return CH_DQUOTE;
      3: return CH_SQUOTE;
      4, 5: return CH_BSLASH;
      6: return 8'($urandom_range(1, 255));
      default: return 8'(8'h61 + $urandom_range(0, 25));
    endcase
  endfunction

  // quotes, separators and byte extremes with marks dropped
  task automatic test_quoted_spans();
    set_split_only(1'b0);
    send_text("\t\"a b\"'c' \377\001");
  endtask

  // escapes, quote inside the other quote, backslash as final byte, unclosed quote
  task automatic test_escapes();
    set_split_only(1'b1);
    send_text("\\\\\\\"\\z\"\\\"'\\");
  endtask

  task automatic test_random_strings(input logic v, input int n_bytes);
    int   sent;
    int   len;
    bit   noise;
    logic [7:0] b;
    set_split_only(v);
    sent = 0;
    while (sent < n_bytes) begin
      len   = $urandom_range(1, 20);
      noise = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < len; i++) begin
        b = noise ? 8'($urandom_range(1, 255)) : pick_byte();
        send_word(b, i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.is_last = 1'b0;
    out_ch.ready  = 1'b0;
    in_up         = 1'b0;
    burst_left    = 0;
    ready_mode    = 0;
    mode_left     = 0;
    mode_tick     = 0;
    mismatches    = 0;
    cycles        = 0;
    keep_marks    = 1'b0;
    esc_pending   = 1'b0;
    esc_byte      = 8'h00;
    quote_open    = Q_NONE;
    arg_open      = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_quoted_spans();
    test_escapes();
    test_random_strings(1'b0, 42);
    test_random_strings(1'b1, 42);
    test_random_strings(1'b1, 42);
    test_random_strings(1'b0, 42);
    test_random_strings(1'($urandom_range(0, 1)), 42);

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (due_words.size() != 0) begin
      mismatches++;
      $display("%0d expected words never arrived", due_words.size());
    end
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
